// ===== hdl/uft_pkg.sv =====
// Shared codes and sizes for the UART frame FIFO timing block.
package uft_pkg;

  // Request codes carried by req_type.
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_TX_PUSH   = 3'd1;
  localparam logic [2:0] REQ_TX_CANCEL = 3'd2;
  localparam logic [2:0] REQ_RX_IN     = 3'd3;
  localparam logic [2:0] REQ_RX_POP    = 3'd4;
  localparam logic [2:0] REQ_RX_EN     = 3'd5;

  // Event codes carried by event_kind.
  localparam logic [2:0] EV_TX_START    = 3'd0;
  localparam logic [2:0] EV_TX_SENT     = 3'd1;
  localparam logic [2:0] EV_TX_COMPLETE = 3'd2;
  localparam logic [2:0] EV_RX_START    = 3'd3;
  localparam logic [2:0] EV_RX_COMPLETE = 3'd4;
  localparam logic [2:0] EV_POP_DATA    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BIT_DELAY = 2'd0;
  localparam logic [1:0] CFG_TX_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_RX_LIMIT  = 2'd2;

  // Most events one request can raise.
  localparam int EV_MAX = 5;

endpackage

// ===== hdl/uft_if.sv =====
// Word channel interfaces for requests and events.
interface uft_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] frame_data;
  logic       enable_value;
  modport source (output valid, req_type, frame_data, enable_value, input ready);
  modport sink (input valid, req_type, frame_data, enable_value, output ready);
endinterface

interface uft_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] event_value;
  logic       last;
  logic       collision_flag;
  logic       overrun_flag;
  logic [4:0] ready_count;
  modport source (output valid, event_kind, event_value, last, collision_flag,
                  overrun_flag, ready_count, input ready);
  modport sink (input valid, event_kind, event_value, last, collision_flag,
                overrun_flag, ready_count, output ready);
endinterface

// ===== hdl/uart_frame_fifo_timing.sv =====
// Top level of the UART frame FIFO timing block.
//
//  Channel  Role    Word contents
//  req      sink    req_type, frame_data, enable_value
//  rsp      source  event_kind, event_value, last, flags, ready_count
//  cfg      write   cfg_we, cfg_addr, cfg_data (bit_delay, tx_limit, rx_limit)
//
// A request is taken in the idle cycle and then passes through the sequencer states; a tick
// that sends a TX frame, starts the next one and starts a reception takes the longest path,
// since each frame RAM read adds a state. Its event words then drain one per cycle as rsp
// accepts them. A stall on rsp holds the block.
// Reset is synchronous; the RAMs need no clearing pass, only pointers reset.
module uart_frame_fifo_timing #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  uft_req_if.sink                 req,
  uft_evt_if.source               rsp,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [15:0]             cfg_data
);
  import uft_pkg::*;

  localparam int TAW = $clog2(TX_DEPTH);
  localparam int TFW = $clog2(TX_DEPTH + 1);
  localparam int RAW = $clog2(RX_DEPTH);
  localparam int RFW = $clog2(RX_DEPTH + 1);
  localparam int TCW = (TFW > 5) ? TFW : 5;
  localparam int RCW = (RFW > 5) ? RFW : 5;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_TX    = 10'b0000000100,
    S_TXA   = 10'b0000001000,
    S_TXB   = 10'b0000010000,
    S_RX    = 10'b0000100000,
    S_RXST  = 10'b0001000000,
    S_RXS   = 10'b0010000000,
    S_POP   = 10'b0100000000,
    S_DRAIN = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [15:0] bit_delay;
  logic [4:0]  tx_limit, rx_limit;

  logic [2:0] req_q;
  logic [7:0] data_q;
  logic       en_q;

  logic [TAW-1:0] tx_head, tx_head_next;
  logic [TFW-1:0] tx_fill, tx_fill_next;
  logic [15:0]    tx_cd, tx_cd_next;
  logic [RAW-1:0] rx_head, rx_head_next;
  logic [RFW-1:0] rx_fill, rx_fill_next;
  logic [RFW-1:0] rx_front, rx_front_next;
  logic [15:0]    rx_cd, rx_cd_next;
  logic           rx_enabled, rx_enabled_next;
  logic           tx_collided, tx_collided_next;
  logic           rx_overran, rx_overran_next;

  // Event buffer for one request.
  logic [2:0] ev_kind [EV_MAX];
  logic [7:0] ev_val [EV_MAX];
  logic [2:0] ev_n, ev_n_next;
  logic [2:0] rd_idx;
  logic       e0_we, e1_we;
  logic [2:0] e0_k, e1_k;
  logic [7:0] e0_v, e1_v;

  // RAM ports.
  logic           tx_we, rx_we;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [RAW-1:0] rx_waddr, rx_raddr;
  logic [7:0]     tx_wdata, tx_rdata, rx_wdata, rx_rdata;

  logic [15:0]    dly;
  logic [TCW-1:0] tx_lim;
  logic [TFW-1:0] tf_t;
  logic [RAW-1:0] rh_t;
  logic [RFW-1:0] rf_t, rfr_t;

  function automatic logic [TAW-1:0] tx_wrap(input logic [TFW:0] s);
    logic [TFW:0] d;
    d = (TFW + 1)'(TX_DEPTH);
    return (s >= d) ? TAW'(s - d) : TAW'(s);
  endfunction

  function automatic logic [RAW-1:0] rx_wrap(input logic [RFW:0] s);
    logic [RFW:0] d;
    d = (RFW + 1)'(RX_DEPTH);
    return (s >= d) ? RAW'(s - d) : RAW'(s);
  endfunction

  uft_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
    .raddr(tx_raddr), .rdata(tx_rdata)
  );

  uft_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rx_raddr), .rdata(rx_rdata)
  );

  // Frame time, with zero treated as one tick, and the effective TX limit.
  assign dly = (bit_delay == 16'd0) ? 16'd1 : bit_delay;
  assign tx_lim = (tx_limit != 5'd0 && TCW'(tx_limit) < TCW'(TX_DEPTH)) ?
                  TCW'(tx_limit) : TCW'(TX_DEPTH);

  // Handshake and result word.
  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = (state == S_DRAIN) && (ev_n != 3'd0);
  assign rsp.event_kind      = ev_kind[rd_idx];
  assign rsp.event_value     = ev_val[rd_idx];
  assign rsp.last            = (rd_idx == ev_n - 3'd1);
  assign rsp.collision_flag  = tx_collided;
  assign rsp.overrun_flag    = rx_overran;
  assign rsp.ready_count     = 5'(rx_front);

  // Sequencer: read, modify and write back the queue state.
  always_comb begin
    state_next       = state;
    tx_head_next     = tx_head;
    tx_fill_next     = tx_fill;
    tx_cd_next       = tx_cd;
    rx_head_next     = rx_head;
    rx_fill_next     = rx_fill;
    rx_front_next    = rx_front;
    rx_cd_next       = rx_cd;
    rx_enabled_next  = rx_enabled;
    tx_collided_next = tx_collided;
    rx_overran_next  = rx_overran;
    ev_n_next        = ev_n;
    e0_we = 1'b0; e0_k = EV_TX_START; e0_v = 8'd0;
    e1_we = 1'b0; e1_k = EV_TX_START; e1_v = 8'd0;
    tx_we = 1'b0; tx_waddr = tx_head; tx_wdata = data_q; tx_raddr = tx_head;
    rx_we = 1'b0; rx_waddr = rx_head; rx_wdata = data_q; rx_raddr = rx_head;
    tf_t  = tx_fill;
    rh_t  = rx_head;
    rf_t  = rx_fill;
    rfr_t = rx_front;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          ev_n_next  = 3'd0;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_DRAIN;
        case (req_q)
          REQ_TICK: state_next = S_TX;
          REQ_TX_PUSH: begin
            if (TCW'(tx_fill) >= tx_lim && tx_fill != '0) begin
              tf_t             = tx_fill - TFW'(1);
              tx_collided_next = 1'b1;
            end
            tx_we        = 1'b1;
            tx_waddr     = tx_wrap((TFW + 1)'(tx_head) + (TFW + 1)'(tf_t));
            tx_fill_next = tf_t + TFW'(1);
            if (tx_cd == 16'd0) begin
              e0_we      = 1'b1;
              e0_k       = EV_TX_START;
              e0_v       = data_q;
              ev_n_next  = ev_n + 3'd1;
              tx_cd_next = dly;
            end
          end
          REQ_TX_CANCEL: begin
            if (tx_fill > TFW'(1)) tx_fill_next = TFW'(1);
          end
          REQ_RX_IN: begin
            if (rx_fill >= RFW'(RX_DEPTH)) begin
              rx_overran_next = 1'b1;
            end else begin
              rx_we        = 1'b1;
              rx_waddr     = rx_wrap((RFW + 1)'(rx_head) + (RFW + 1)'(rx_fill));
              rx_fill_next = rx_fill + RFW'(1);
              if (rx_cd == 16'd0) state_next = S_RXST;
            end
          end
          REQ_RX_POP: begin
            if (rx_front != '0 && rx_fill != '0) begin
              rx_raddr   = rx_head;
              state_next = S_POP;
            end else begin
              e0_we     = 1'b1;
              e0_k      = EV_POP_DATA;
              ev_n_next = ev_n + 3'd1;
            end
          end
          REQ_RX_EN: begin
            rx_enabled_next = en_q;
            if (!en_q) begin
              if (rx_cd != 16'd0) begin
                e0_we      = 1'b1;
                e0_k       = EV_RX_COMPLETE;
                ev_n_next  = ev_n + 3'd1;
                rx_cd_next = 16'd0;
              end
              rfr_t           = (rx_front > rx_fill) ? rx_fill : rx_front;
              rx_head_next    = rx_wrap((RFW + 1)'(rx_head) + (RFW + 1)'(rfr_t));
              rx_fill_next    = rx_fill - rfr_t;
              rx_front_next   = '0;
              rx_overran_next = 1'b0;
            end
          end
          default: ;
        endcase
      end

      // TX timer; on expiry read the frame at the head.
      S_TX: begin
        state_next = S_RX;
        if (tx_cd != 16'd0) begin
          tx_cd_next = tx_cd - 16'd1;
          if (tx_cd == 16'd1 && tx_fill != '0) begin
            tx_raddr   = tx_head;
            state_next = S_TXA;
          end
        end
      end

      S_TXA: begin
        e0_we = 1'b1; e0_k = EV_TX_SENT;     e0_v = tx_rdata;
        e1_we = 1'b1; e1_k = EV_TX_COMPLETE; e1_v = 8'd1;
        ev_n_next    = ev_n + 3'd2;
        tx_head_next = tx_wrap((TFW + 1)'(tx_head) + (TFW + 1)'(1));
        tx_fill_next = tx_fill - TFW'(1);
        if (tx_fill > TFW'(1)) begin
          tx_raddr   = tx_head_next;
          state_next = S_TXB;
        end else begin
          state_next = S_RX;
        end
      end

      S_TXB: begin
        e0_we = 1'b1; e0_k = EV_TX_START; e0_v = tx_rdata;
        ev_n_next  = ev_n + 3'd1;
        tx_cd_next = dly;
        state_next = S_RX;
      end

      // RX timer; on expiry keep or discard the frame on the wire.
      S_RX: begin
        state_next = S_DRAIN;
        if (rx_cd != 16'd0) begin
          rx_cd_next = rx_cd - 16'd1;
          if (rx_cd == 16'd1) begin
            e0_we     = 1'b1;
            e0_k      = EV_RX_COMPLETE;
            ev_n_next = ev_n + 3'd1;
            if (rx_enabled) begin
              if (rx_front < rx_fill) rfr_t = rx_front + RFW'(1);
              e0_v = 8'd1;
            end else if (rx_fill != '0) begin
              rh_t = rx_wrap((RFW + 1)'(rx_head) + (RFW + 1)'(1));
              rf_t = rx_fill - RFW'(1);
              if (rx_front != '0) rfr_t = rx_front - RFW'(1);
            end
            rx_head_next  = rh_t;
            rx_fill_next  = rf_t;
            rx_front_next = rfr_t;
            if (rfr_t < rf_t) state_next = S_RXST;
          end
        end
      end

      // Start a reception, dropping the oldest readable frame at the limit.
      S_RXST: begin
        if (rx_limit != 5'd0 && RCW'(rx_front) >= RCW'(rx_limit) && rx_front != '0) begin
          rh_t            = rx_wrap((RFW + 1)'(rx_head) + (RFW + 1)'(1));
          rf_t            = rx_fill - RFW'(1);
          rfr_t           = rx_front - RFW'(1);
          rx_overran_next = 1'b1;
        end
        rx_head_next  = rh_t;
        rx_fill_next  = rf_t;
        rx_front_next = rfr_t;
        rx_raddr      = rx_wrap((RFW + 1)'(rh_t) + (RFW + 1)'(rfr_t));
        state_next    = S_RXS;
      end

      S_RXS: begin
        e0_we = 1'b1; e0_k = EV_RX_START; e0_v = rx_rdata;
        ev_n_next  = ev_n + 3'd1;
        rx_cd_next = dly;
        state_next = S_DRAIN;
      end

      S_POP: begin
        e0_we = 1'b1; e0_k = EV_POP_DATA; e0_v = rx_rdata;
        ev_n_next     = ev_n + 3'd1;
        rx_head_next  = rx_wrap((RFW + 1)'(rx_head) + (RFW + 1)'(1));
        rx_fill_next  = rx_fill - RFW'(1);
        rx_front_next = rx_front - RFW'(1);
        state_next    = S_DRAIN;
      end

      S_DRAIN: begin
        if (ev_n == 3'd0) begin
          state_next = S_IDLE;
        end else if (rsp.ready && rsp.last) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tx_head     <= '0;
      tx_fill     <= '0;
      tx_cd       <= '0;
      rx_head     <= '0;
      rx_fill     <= '0;
      rx_front    <= '0;
      rx_cd       <= '0;
      rx_enabled  <= 1'b0;
      tx_collided <= 1'b0;
      rx_overran  <= 1'b0;
      ev_n        <= '0;
      rd_idx      <= '0;
    end else begin
      state       <= state_next;
      tx_head     <= tx_head_next;
      tx_fill     <= tx_fill_next;
      tx_cd       <= tx_cd_next;
      rx_head     <= rx_head_next;
      rx_fill     <= rx_fill_next;
      rx_front    <= rx_front_next;
      rx_cd       <= rx_cd_next;
      rx_enabled  <= rx_enabled_next;
      tx_collided <= tx_collided_next;
      rx_overran  <= rx_overran_next;
      ev_n        <= ev_n_next;
      if (state == S_IDLE) begin
        rd_idx <= '0;
      end else if (rsp.valid && rsp.ready) begin
        rd_idx <= rd_idx + 3'd1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_delay <= 16'd1;
      tx_limit  <= 5'd0;
      rx_limit  <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BIT_DELAY: bit_delay <= cfg_data;
        CFG_TX_LIMIT:  tx_limit  <= cfg_data[4:0];
        CFG_RX_LIMIT:  rx_limit  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Request word and event buffer payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_q  <= req.req_type;
      data_q <= req.frame_data;
      en_q   <= req.enable_value;
    end
    for (int i = 0; i < EV_MAX; i++) begin
      if (e0_we && ev_n == 3'(i)) begin
        ev_kind[i] <= e0_k;
        ev_val[i]  <= e0_v;
      end
      if (e1_we && ev_n + 3'd1 == 3'(i)) begin
        ev_kind[i] <= e1_k;
        ev_val[i]  <= e1_v;
      end
    end
  end
endmodule

// ===== hdl/uft_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
module uft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/uft_checker.sv =====
// Port-level checks for the UART frame FIFO timing block, and their binding.
module uft_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  // No event word is offered while a new request can be taken.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(out_valid && in_ready))
    else $error("event word offered while request port is ready");

  // After a request is taken the block is not ready in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
                           (in_valid && in_ready) |=> !in_ready)
    else $error("request port ready straight after a request");

  // After a non-final word is taken, another word follows.
  a_more: assert property (@(posedge clk) disable iff (rst)
                           (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("event sequence ended without a last word");

  // A stalled event word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
                           (out_valid && !out_ready) |=> out_valid)
    else $error("event word withdrawn while stalled");
endmodule

bind uart_frame_fifo_timing uft_checker u_uft_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_last(rsp.last)
);

// ===== test/uart_frame_fifo_timing_tb.sv =====
// Self-checking testbench for the UART frame FIFO timing block.
`timescale 1ns / 1ps

module uart_frame_fifo_timing_tb;
  import uft_pkg::*;

  localparam int TXD = 16;
  localparam int RXD = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DUE_DEPTH = 64;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_data;

  uft_req_if req ();
  uft_evt_if rsp ();

  uart_frame_fifo_timing #(.TX_DEPTH(TXD), .RX_DEPTH(RXD)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // One expected event word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
    logic       collision;
    logic       overrun;
    logic [4:0] ready_count;
  } event_word_t;

  // Ring of expected words, written at acceptance and read by the checker.
  event_word_t due_words[DUE_DEPTH];
  int          due_wr, due_rd;

  int  mismatches;
  int  failures;
  int  idle_cycles;
  bit  offering;
  int  next_gap;
  bit  no_idle;
  bit  hold_req;

  // Shadow of the block's configuration and state.
  logic [15:0] m_bit_delay;
  logic [4:0]  shadow_tx_lim, shadow_rx_lim;
  logic [7:0]  m_tx_mem[TXD];
  logic [7:0]  m_rx_mem[RXD];
  int          m_tx_head, m_tx_fill, m_tx_count;
  int          m_rx_head, m_rx_fill, m_rx_front, rx_ticks_left;
  bit          m_rx_on, m_collided, m_overran;
  logic [2:0]  pend_kind[8];
  logic [7:0]  pend_val[8];
  int          n_pend;

  // Clock.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void due_put(event_word_t w);
    due_words[due_wr % DUE_DEPTH] = w;
    due_wr++;
  endfunction

  function automatic event_word_t due_take();
    event_word_t w;
    w = due_words[due_rd % DUE_DEPTH];
    due_rd++;
    return w;
  endfunction

  function automatic void note(logic [2:0] k, logic [7:0] v);
    if (n_pend < 8) begin
      pend_kind[n_pend] = k;
      pend_val[n_pend] = v;
      n_pend++;
    end
  endfunction

  function automatic int frame_ticks();
    return (m_bit_delay == 16'd0) ? 1 : int'(m_bit_delay);
  endfunction

  function automatic void begin_rx_frame();
    if (shadow_rx_lim > 0 && m_rx_front >= shadow_rx_lim && m_rx_front > 0) begin
      m_rx_head = (m_rx_head + 1) % RXD;
      m_rx_fill--;
      m_rx_front--;
      m_overran = 1'b1;
    end
    note(EV_RX_START, m_rx_mem[(m_rx_head + m_rx_front) % RXD]);
  endfunction

  function automatic void tick_tx();
    if (m_tx_count == 0) return;
    m_tx_count--;
    if (m_tx_count != 0 || m_tx_fill == 0) return;
    note(EV_TX_SENT, m_tx_mem[m_tx_head]);
    m_tx_head = (m_tx_head + 1) % TXD;
    m_tx_fill--;
    note(EV_TX_COMPLETE, 8'd1);
    if (m_tx_fill > 0) begin
      note(EV_TX_START, m_tx_mem[m_tx_head]);
      m_tx_count = frame_ticks();
    end
  endfunction

  function automatic void tick_rx();
    if (rx_ticks_left == 0) return;
    rx_ticks_left--;
    if (rx_ticks_left != 0) return;
    if (m_rx_on) begin
      if (m_rx_front < m_rx_fill) m_rx_front++;
      note(EV_RX_COMPLETE, 8'd1);
    end else begin
      if (m_rx_fill > 0) begin
        m_rx_head = (m_rx_head + 1) % RXD;
        m_rx_fill--;
        if (m_rx_front > 0) m_rx_front--;
      end
      note(EV_RX_COMPLETE, 8'd0);
    end
    if (m_rx_front < m_rx_fill) begin
      begin_rx_frame();
      rx_ticks_left = frame_ticks();
    end
  endfunction

  // Works out the event words one accepted request raises.
  function automatic void predict_events(logic [2:0] kind, logic [7:0] data, logic en);
    bit busy;
    int lim;
    event_word_t w;
    n_pend = 0;
    case (kind)
      REQ_TICK: begin
        tick_tx();
        tick_rx();
      end
      REQ_TX_PUSH: begin
        busy = (m_tx_count != 0);
        lim = (shadow_tx_lim > 0 && shadow_tx_lim < TXD) ? int'(shadow_tx_lim) : TXD;
        if (m_tx_fill >= lim && m_tx_fill > 0) begin
          m_tx_fill--;
          m_collided = 1'b1;
        end
        m_tx_mem[(m_tx_head + m_tx_fill) % TXD] = data;
        m_tx_fill++;
        if (!busy) begin
          note(EV_TX_START, data);
          m_tx_count = frame_ticks();
        end
      end
      REQ_TX_CANCEL: begin
        if (m_tx_fill > 1) m_tx_fill = 1;
      end
      REQ_RX_IN: begin
        busy = (rx_ticks_left != 0);
        if (m_rx_fill >= RXD) begin
          m_overran = 1'b1;
        end else begin
          m_rx_mem[(m_rx_head + m_rx_fill) % RXD] = data;
          m_rx_fill++;
          if (!busy) begin
            begin_rx_frame();
            rx_ticks_left = frame_ticks();
          end
        end
      end
      REQ_RX_POP: begin
        if (m_rx_front > 0 && m_rx_fill > 0) begin
          note(EV_POP_DATA, m_rx_mem[m_rx_head]);
          m_rx_head = (m_rx_head + 1) % RXD;
          m_rx_fill--;
          m_rx_front--;
        end else begin
          note(EV_POP_DATA, 8'd0);
        end
      end
      REQ_RX_EN: begin
        m_rx_on = en;
        if (!en) begin
          if (rx_ticks_left != 0) begin
            note(EV_RX_COMPLETE, 8'd0);
            rx_ticks_left = 0;
          end
          if (m_rx_front > m_rx_fill) m_rx_front = m_rx_fill;
          m_rx_head = (m_rx_head + m_rx_front) % RXD;
          m_rx_fill -= m_rx_front;
          m_rx_front = 0;
          m_overran = 1'b0;
        end
      end
      default: ;
    endcase
    if (n_pend > EV_MAX) n_pend = EV_MAX;
    for (int k = 0; k < n_pend; k++) begin
      w.kind = pend_kind[k];
      w.value = pend_val[k];
      w.last = (k == n_pend - 1);
      w.collision = m_collided;
      w.overrun = m_overran;
      w.ready_count = m_rx_front[4:0];
      due_put(w);
    end
  endfunction

  // Offers one request word; valid stays up only when the next one follows at once.
  task automatic send_req(logic [2:0] kind, logic [7:0] data, logic en);
    if (next_gap > 0) begin
      repeat (next_gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.frame_data <= data;
    req.enable_value <= en;
    offering = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_events(kind, data, en);
    next_gap = no_idle ? 0 : $urandom_range(0, 8);
    if (next_gap > 0) begin
      req.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Drops valid, waits for every event word and lets the block go quiet.
  task automatic settle();
    if (offering) begin
      req.valid <= 1'b0;
      offering = 1'b0;
    end
    next_gap = 1;
    while (due_wr != due_rd) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // One register write; the write enable is then dropped and the shadow copy updated.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BIT_DELAY: m_bit_delay = val;
      CFG_TX_LIMIT:  shadow_tx_lim = val[4:0];
      CFG_RX_LIMIT:  shadow_rx_lim = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] delay, logic [4:0] txl, logic [4:0] rxl);
    write_reg(CFG_BIT_DELAY, delay);
    write_reg(CFG_TX_LIMIT, {11'd0, txl});
    write_reg(CFG_RX_LIMIT, {11'd0, rxl});
  endtask

  // Draws one request with a bias towards ticks so frames finish.
  task automatic send_random_req(bit allow_tx);
    int r;
    logic [2:0] kind;
    logic       en;
    r = $urandom_range(0, 99);
    en = 1'b1;
    if (r < 38) kind = REQ_TICK;
    else if (r < 53) kind = allow_tx ? REQ_TX_PUSH : REQ_TICK;
    else if (r < 57) kind = REQ_TX_CANCEL;
    else if (r < 73) kind = REQ_RX_IN;
    else if (r < 88) kind = REQ_RX_POP;
    else if (r < 97) begin
      kind = REQ_RX_EN;
      en = ($urandom_range(0, 3) != 0);
    end else kind = 3'($urandom_range(6, 7));
    send_req(kind, 8'($urandom), en);
  endtask

  task automatic run_phase(int n, logic [15:0] delay, logic [4:0] txl, logic [4:0] rxl,
                           bit fast);
    set_config(delay, txl, rxl);
    no_idle = fast;
    send_req(REQ_RX_EN, 8'h00, 1'b1);
    for (int i = 0; i < n; i++) send_random_req(1'b1);
    no_idle = 1'b0;
    settle();
  endtask

  // Directed corners: empty pop, disabled receiver, extremes, collisions, unused codes.
  task automatic test_directed();
    set_config(16'd1, 5'd1, 5'd1);
    send_req(REQ_RX_POP, 8'h00, 1'b0);
    send_req(REQ_RX_IN, 8'hA5, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    send_req(REQ_RX_EN, 8'h00, 1'b1);
    send_req(REQ_RX_IN, 8'hFF, 1'b0);
    send_req(REQ_RX_IN, 8'h00, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    send_req(REQ_RX_POP, 8'h00, 1'b0);
    send_req(REQ_TX_PUSH, 8'h00, 1'b0);
    send_req(REQ_TX_PUSH, 8'hFF, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    send_req(REQ_TX_PUSH, 8'h5A, 1'b0);
    send_req(REQ_TX_PUSH, 8'h3C, 1'b0);
    send_req(REQ_TX_CANCEL, 8'h00, 1'b0);
    send_req(3'd6, 8'hFF, 1'b1);
    send_req(3'd7, 8'h00, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    settle();
    // Zero delay acts as one; receiver switched off mid frame.
    set_config(16'd0, 5'd16, 5'd16);
    send_req(REQ_RX_IN, 8'h81, 1'b0);
    send_req(REQ_RX_EN, 8'h00, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    send_req(REQ_TX_PUSH, 8'h7E, 1'b0);
    send_req(REQ_TICK, 8'h00, 1'b0);
    settle();
  endtask

  // Longest frame time on the receive side only, then cancelled by disabling it.
  task automatic test_long_delay();
    set_config(16'hFFFF, 5'd0, 5'd0);
    send_req(REQ_RX_EN, 8'h00, 1'b1);
    send_req(REQ_RX_IN, 8'h42, 1'b0);
    for (int i = 0; i < 10; i++) send_random_req(1'b0);
    send_req(REQ_RX_EN, 8'h00, 1'b0);
    settle();
  endtask

  // Fills the RX store past its depth so incoming frames overrun.
  task automatic test_rx_store_full();
    set_config(16'd3, 5'd0, 5'd0);
    send_req(REQ_RX_EN, 8'h00, 1'b1);
    for (int i = 0; i < 20; i++) send_req(REQ_RX_IN, 8'($urandom), 1'b0);
    for (int i = 0; i < 60; i++) send_req(REQ_TICK, 8'h00, 1'b0);
    for (int i = 0; i < 18; i++) send_req(REQ_RX_POP, 8'h00, 1'b0);
    settle();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    set_config(16'd1, 5'd4, 5'd2);
    send_req(REQ_RX_EN, 8'h00, 1'b1);
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_random_req(1'b1);
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random();
    run_phase(45, 16'd1, 5'd0, 5'd0, 1'b0);
    run_phase(45, 16'd2, 5'd1, 5'd1, 1'b1);
    run_phase(45, 16'd3, 5'd16, 5'd16, 1'b0);
    run_phase(45, 16'($urandom_range(1, 4)), 5'($urandom_range(0, 16)),
              5'($urandom_range(0, 16)), 1'b0);
    run_phase(45, 16'd1, 5'd3, 5'd5, 1'b0);
    // Lower the TX limit below the current fill.
    set_config(16'd2, 5'd0, 5'd0);
    for (int i = 0; i < 10; i++) send_req(REQ_TX_PUSH, 8'($urandom), 1'b0);
    settle();
    write_reg(CFG_TX_LIMIT, 16'd2);
    for (int i = 0; i < 60; i++) send_random_req(1'b1);
    settle();
  endtask

  // Event word checker.
  always @(posedge clk) begin
    event_word_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_wr == due_rd) begin
        failures++;
        if (mismatches < 10)
          $display("unexpected event word: kind %0d value %02h", rsp.event_kind,
                   rsp.event_value);
        mismatches++;
      end else begin
        w = due_take();
        if (rsp.event_kind !== w.kind || rsp.event_value !== w.value ||
            rsp.last !== w.last || rsp.collision_flag !== w.collision ||
            rsp.overrun_flag !== w.overrun || rsp.ready_count !== w.ready_count) begin
          failures++;
          if (mismatches < 10)
            $display({"mismatch: exp k%0d v%02h l%0b c%0b o%0b n%0d",
                      " got k%0d v%02h l%0b c%0b o%0b n%0d"},
                     w.kind, w.value, w.last, w.collision, w.overrun, w.ready_count,
                     rsp.event_kind, rsp.event_value, rsp.last, rsp.collision_flag,
                     rsp.overrun_flag, rsp.ready_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no word accepted on either channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Event receiver with random stalls and one long hold-off on request.
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    mismatches = 0;
    failures = 0;
    idle_cycles = 0;
    due_wr = 0;
    due_rd = 0;
    offering = 1'b0;
    next_gap = 1;
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.req_type = REQ_TICK;
    req.frame_data = '0;
    req.enable_value = 1'b0;
    m_bit_delay = 16'd1;
    shadow_tx_lim = '0;
    shadow_rx_lim = '0;
    m_tx_head = 0; m_tx_fill = 0; m_tx_count = 0;
    m_rx_head = 0; m_rx_fill = 0; m_rx_front = 0; rx_ticks_left = 0;
    m_rx_on = 1'b0; m_collided = 1'b0; m_overran = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_long_delay();
    test_rx_store_full();
    test_backpressure();
    test_random();

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
